### rtl/core/lse_pkg.sv
// ----------------------------------------------------------------------------
// lse_pkg
// Shared widths, control word layout and microcode for the Legendre series
// evaluator.
// ----------------------------------------------------------------------------
package lse_pkg;

    localparam int ORD_W         = 4;
    localparam int MAX_ORDER_DEF = 10;
    localparam int X_W           = 16;
    localparam int C_W           = 32;
    localparam int P_W           = 32;
    localparam int ACC_W         = 48;
    localparam int K_W           = 21;
    localparam int NUM_W         = 54;
    localparam int A_W           = 50;
    localparam int DIV_W         = 38;
    localparam int STEP_W        = 4;

    localparam logic signed [P_W-1:0] P_ONE = 32'sh4000_0000;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_FULLCHK,
        OP_KMUL,
        OP_NUM,
        OP_SUBP2,
        OP_DIVLD,
        OP_DIVRUN,
        OP_PUPD,
        OP_CPMUL,
        OP_TERM,
        OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_GOTO,
        JMP_IF,
        JMP_WAIT
    } jmp_t;

    typedef enum logic [2:0] {
        COND_XFER,
        COND_FULL,
        COND_ZERO,
        COND_DIV_LAST,
        COND_NO_LAST,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        logic              in_rdy;
        op_t               op;
        jmp_t              jmp;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic             xfer;
        logic             full;
        logic             zero;
        logic             div_last;
        logic             last;
        logic             out_free;
        logic [ORD_W-1:0] order;
    } stat_t;

    localparam logic [STEP_W-1:0] ST_FETCH  = 4'd0;
    localparam logic [STEP_W-1:0] ST_CHK    = 4'd1;
    localparam logic [STEP_W-1:0] ST_KMUL   = 4'd2;
    localparam logic [STEP_W-1:0] ST_NUM    = 4'd3;
    localparam logic [STEP_W-1:0] ST_SUBP2  = 4'd4;
    localparam logic [STEP_W-1:0] ST_DIVLD  = 4'd5;
    localparam logic [STEP_W-1:0] ST_DIVRUN = 4'd6;
    localparam logic [STEP_W-1:0] ST_PUPD   = 4'd7;
    localparam logic [STEP_W-1:0] ST_CPMUL  = 4'd8;
    localparam logic [STEP_W-1:0] ST_TERM   = 4'd9;
    localparam logic [STEP_W-1:0] ST_CLOSE  = 4'd10;
    localparam logic [STEP_W-1:0] ST_EMIT   = 4'd11;

    // microcode ROM
    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t cw;
        case (step)
            ST_FETCH:  cw = ctrl_t'{1'b1, OP_LOAD,    JMP_WAIT, COND_XFER,     ST_CHK};
            ST_CHK:    cw = ctrl_t'{1'b0, OP_FULLCHK, JMP_IF,   COND_FULL,     ST_CLOSE};
            ST_KMUL:   cw = ctrl_t'{1'b0, OP_KMUL,    JMP_IF,   COND_ZERO,     ST_CPMUL};
            ST_NUM:    cw = ctrl_t'{1'b0, OP_NUM,     JMP_NEXT, COND_XFER,     ST_FETCH};
            ST_SUBP2:  cw = ctrl_t'{1'b0, OP_SUBP2,   JMP_NEXT, COND_XFER,     ST_FETCH};
            ST_DIVLD:  cw = ctrl_t'{1'b0, OP_DIVLD,   JMP_NEXT, COND_XFER,     ST_FETCH};
            ST_DIVRUN: cw = ctrl_t'{1'b0, OP_DIVRUN,  JMP_WAIT, COND_DIV_LAST, ST_PUPD};
            ST_PUPD:   cw = ctrl_t'{1'b0, OP_PUPD,    JMP_NEXT, COND_XFER,     ST_FETCH};
            ST_CPMUL:  cw = ctrl_t'{1'b0, OP_CPMUL,   JMP_NEXT, COND_XFER,     ST_FETCH};
            ST_TERM:   cw = ctrl_t'{1'b0, OP_TERM,    JMP_NEXT, COND_XFER,     ST_FETCH};
            ST_CLOSE:  cw = ctrl_t'{1'b0, OP_NOP,     JMP_IF,   COND_NO_LAST,  ST_FETCH};
            ST_EMIT:   cw = ctrl_t'{1'b0, OP_EMIT,    JMP_WAIT, COND_OUT_FREE, ST_FETCH};
            default:   cw = ctrl_t'{1'b0, OP_NOP,     JMP_GOTO, COND_XFER,     ST_FETCH};
        endcase
        return cw;
    endfunction

endpackage

### rtl/core/lse_div.sv
// ----------------------------------------------------------------------------
// lse_div
// Radix-2 restoring divider of the rounded recurrence numerator by the order,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lse_div
    import lse_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  logic             run,
    input  logic [DIV_W-1:0] dividend,
    input  logic [ORD_W-1:0] divisor,
    output logic [DIV_W-1:0] quot,
    output logic             last_step
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] quo_reg;
    logic [ORD_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [ORD_W:0]   trial;
    logic [ORD_W:0]   diff;
    logic             ge;
    logic [ORD_W-1:0] rem_next;

    always_comb begin
        trial    = {rem_reg, quo_reg[DIV_W-1]};
        diff     = trial - {1'b0, divisor};
        ge       = (trial >= {1'b0, divisor});
        rem_next = ge ? diff[ORD_W-1:0] : trial[ORD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (load) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            cnt_reg <= CNT_W'(DIV_W);
        end else if (run && cnt_reg != '0) begin
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign quot      = quo_reg;
    assign last_step = (cnt_reg == CNT_W'(1));

endmodule

### rtl/core/lse_dp.sv
// ----------------------------------------------------------------------------
// lse_dp
// Datapath: series state, multiplies, recurrence, term accumulation
// and the result register.
// ----------------------------------------------------------------------------
module lse_dp
    import lse_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  ctrl_t                   ctrl,
    input  logic                    xfer,
    input  logic signed [X_W-1:0]   s_abscissa,
    input  logic signed [C_W-1:0]   s_coef,
    input  logic                    s_last,
    input  logic                    m_ready,
    output logic                    m_valid,
    output logic signed [C_W-1:0]   m_sum,
    output logic                    m_overflow,
    output logic                    m_order_error,
    output stat_t                   stat
);

    logic [ORD_W-1:0]        order_reg;
    logic                    full_reg;
    logic signed [X_W-1:0]   x_reg;
    logic signed [P_W-1:0]   pp_reg;
    logic signed [P_W-1:0]   pp2_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic                    sat_reg;
    logic                    err_reg;
    logic signed [C_W-1:0]   coef_reg;
    logic                    last_reg;
    logic signed [K_W-1:0]   k_reg;
    logic signed [NUM_W-1:0] num_reg;
    logic                    neg_reg;
    logic signed [A_W-1:0]   a_reg;
    logic                    m_valid_reg;
    logic signed [C_W-1:0]   m_sum_reg;
    logic                    m_ovf_reg;
    logic                    m_err_reg;

    logic [ORD_W:0]          odd_m;
    logic [ORD_W:0]          odd_p;
    logic [ORD_W-1:0]        lm1;
    logic signed [K_W:0]     kmul;
    logic signed [NUM_W-2:0] nprod;
    logic signed [P_W+ORD_W:0] p2prod;
    logic signed [NUM_W-1:0] num_next;
    logic [NUM_W-1:0]        mag;
    logic [NUM_W-1:0]        rnd;
    logic [DIV_W-1:0]        div_q;
    logic                    div_last;
    logic                    big;
    logic signed [P_W-1:0]   p_new;
    logic                    p_sat;
    logic signed [2*P_W-1:0] cprod;
    logic signed [A_W+ORD_W+1:0] tprod;
    logic signed [A_W+ORD_W+1:0] tsum;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [C_W-1:0]   sum_sat;
    logic                    sum_ovf;
    logic                    out_free;

    always_comb begin
        odd_m    = {order_reg, 1'b0} - 1'b1;
        odd_p    = {order_reg, 1'b1};
        lm1      = order_reg - 1'b1;
        kmul     = x_reg * $signed({1'b0, odd_m});
        nprod    = k_reg * pp_reg;
        p2prod   = pp2_reg * $signed({1'b0, lm1});
        num_next = num_reg - {{(NUM_W-P_W-ORD_W-16){p2prod[P_W+ORD_W]}}, p2prod, 15'b0};
        mag      = num_reg[NUM_W-1] ? (~num_reg + 1'b1) : num_reg;
        rnd      = mag + {{(NUM_W-ORD_W-14){1'b0}}, order_reg, 14'b0};

        big = |div_q[DIV_W-1:P_W-1];
        if (!neg_reg) begin
            p_new = big ? 32'sh7FFF_FFFF : $signed(div_q[P_W-1:0]);
            p_sat = big;
        end else begin
            p_new = big ? 32'sh8000_0000 : -$signed(div_q[P_W-1:0]);
            p_sat = 1'b0;
        end

        cprod    = coef_reg * pp_reg;
        tprod    = a_reg * $signed({1'b0, odd_p});
        tsum     = tprod + (A_W+ORD_W+2)'(65536);
        acc_next = acc_reg + (ACC_W)'($signed(tsum[A_W+ORD_W+1:17]));

        if (!acc_reg[ACC_W-1] && (|acc_reg[ACC_W-2:C_W-1])) begin
            sum_sat = 32'sh7FFF_FFFF;
            sum_ovf = 1'b1;
        end else if (acc_reg[ACC_W-1] && !(&acc_reg[ACC_W-2:C_W-1])) begin
            sum_sat = 32'sh8000_0000;
            sum_ovf = 1'b1;
        end else begin
            sum_sat = acc_reg[C_W-1:0];
            sum_ovf = 1'b0;
        end

        out_free = !m_valid_reg || m_ready;
    end

    lse_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (ctrl.op == OP_DIVLD),
        .run       (ctrl.op == OP_DIVRUN),
        .dividend  (rnd[DIV_W+14:15]),
        .divisor   (order_reg),
        .quot      (div_q),
        .last_step (div_last)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg   <= '0;
            full_reg    <= 1'b0;
            x_reg       <= '0;
            pp_reg      <= '0;
            pp2_reg     <= '0;
            acc_reg     <= '0;
            sat_reg     <= 1'b0;
            err_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_ready && !(ctrl.op == OP_EMIT && out_free)) begin
                m_valid_reg <= 1'b0;
            end
            case (ctrl.op)
                OP_LOAD: begin
                    if (xfer) begin
                        coef_reg <= s_coef;
                        last_reg <= s_last;
                        if (!full_reg && order_reg == '0) begin
                            x_reg   <= s_abscissa;
                            pp2_reg <= '0;
                            pp_reg  <= P_ONE;
                        end
                    end
                end
                OP_FULLCHK: begin
                    if (full_reg) begin
                        err_reg <= 1'b1;
                    end
                end
                OP_KMUL: begin
                    k_reg <= kmul[K_W-1:0];
                end
                OP_NUM: begin
                    num_reg <= {nprod[NUM_W-2], nprod};
                end
                OP_SUBP2: begin
                    num_reg <= num_next;
                end
                OP_DIVLD: begin
                    neg_reg <= num_reg[NUM_W-1];
                end
                OP_PUPD: begin
                    pp2_reg <= pp_reg;
                    pp_reg  <= p_new;
                    if (p_sat) begin
                        sat_reg <= 1'b1;
                    end
                end
                OP_CPMUL: begin
                    a_reg <= cprod[2*P_W-1:14];
                end
                OP_TERM: begin
                    acc_reg <= acc_next;
                    if (order_reg == ORD_W'(MAX_ORDER)) begin
                        full_reg <= 1'b1;
                    end else begin
                        order_reg <= order_reg + 1'b1;
                    end
                end
                OP_EMIT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_sum_reg   <= sum_sat;
                        m_ovf_reg   <= sat_reg | sum_ovf;
                        m_err_reg   <= err_reg;
                        order_reg   <= '0;
                        full_reg    <= 1'b0;
                        x_reg       <= '0;
                        pp_reg      <= '0;
                        pp2_reg     <= '0;
                        acc_reg     <= '0;
                        sat_reg     <= 1'b0;
                        err_reg     <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_sum         = m_sum_reg;
    assign m_overflow    = m_ovf_reg;
    assign m_order_error = m_err_reg;

    assign stat = '{xfer:     xfer,
                    full:     full_reg,
                    zero:     (order_reg == '0),
                    div_last: div_last,
                    last:     last_reg,
                    out_free: out_free,
                    order:    order_reg};

endmodule

### rtl/core/lse_seq.sv
// ----------------------------------------------------------------------------
// lse_seq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module lse_seq
    import lse_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  stat_t stat,
    output ctrl_t ctrl
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    ctrl_t             cw;
    logic              hit;

    always_comb begin
        cw = ucode(step_reg);
        case (cw.cond)
            COND_XFER:     hit = stat.xfer;
            COND_FULL:     hit = stat.full;
            COND_ZERO:     hit = stat.zero;
            COND_DIV_LAST: hit = stat.div_last;
            COND_NO_LAST:  hit = !stat.last;
            COND_OUT_FREE: hit = stat.out_free;
            default:       hit = 1'b0;
        endcase
        case (cw.jmp)
            JMP_NEXT: step_next = step_reg + 1'b1;
            JMP_GOTO: step_next = cw.target;
            JMP_IF:   step_next = hit ? cw.target : step_reg + 1'b1;
            JMP_WAIT: step_next = hit ? cw.target : step_reg;
            default:  step_next = ST_FETCH;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ST_FETCH;
        end else begin
            step_reg <= step_next;
        end
    end

    assign ctrl = cw;

endmodule

### rtl/core/legendre_series_eval_core.sv
// ----------------------------------------------------------------------------
// legendre_series_eval_core
// Legendre series evaluator, f(x) = sum (l+0.5)*c_l*P_l(x), one coefficient
// per input transfer, one result transfer per series.
// ----------------------------------------------------------------------------
// One coefficient is taken at a time; s_ready is high only while the
// sequencer waits at its fetch step. Order 0 runs the check, coefficient
// multiply, term and close steps; a coefficient beyond MAX_ORDER (ignored,
// flags order_error) goes from the check straight to the close; orders 1 to
// MAX_ORDER also form the recurrence numerator and run the radix-2 division
// of it by the order, one quotient bit per cycle, then update P_l. A last
// coefficient loads the result register once the previous one is taken.
// x is Q1.15, coefficients and the sum Q16.16; the sum saturates and sets
// overflow, which also reports a saturated P_l.
module legendre_series_eval_core
    import lse_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [X_W-1:0] s_abscissa,
    input  logic signed [C_W-1:0] s_coef,
    input  logic                  s_last,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [C_W-1:0] m_sum,
    output logic                  m_overflow,
    output logic                  m_order_error
);

    ctrl_t ctrl;
    stat_t stat;

    assign s_ready = ctrl.in_rdy;

    lse_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    lse_dp #(
        .MAX_ORDER (MAX_ORDER)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (ctrl),
        .xfer          (s_valid && s_ready),
        .s_abscissa    (s_abscissa),
        .s_coef        (s_coef),
        .s_last        (s_last),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_sum         (m_sum),
        .m_overflow    (m_overflow),
        .m_order_error (m_order_error),
        .stat          (stat)
    );

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while a coefficient is in progress");

    a_full_at_max: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.full |-> (stat.order == ORD_W'(MAX_ORDER)))
        else $error("series full below MAX_ORDER");

    a_no_fetch_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == OP_DIVRUN) |-> !s_ready)
        else $error("ready during division");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

### tb/legendre_series_eval_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// legendre_series_eval_core_tb
// Streams coefficient series into the Legendre series evaluator and checks
// every result transfer against a bit-exact fixed-point model of the
// recurrence, term scaling and saturation, or a row's typed values. A
// directed table covers the field extremes, x = -1, saturation and overlong
// series; random series follow, with random idling on both channels.
// ----------------------------------------------------------------------------
module legendre_series_eval_core_tb
    import lse_pkg::*;
();

    localparam int     MAX_ORD   = MAX_ORDER_DEF;
    localparam int     N_ITEMS   = 550;
    localparam int     IDLE_LIM  = 3000;
    localparam longint P_MAX     = 64'sd2147483647;
    localparam longint P_MIN     = -64'sd2147483648;
    localparam longint Q_CLAMP   = 64'sd2147483648;

    localparam logic signed [X_W-1:0] X_NEG1 = 16'sh8000;
    localparam logic signed [X_W-1:0] X_MAX  = 16'sh7FFF;
    localparam logic signed [C_W-1:0] C_ONE  = 32'sh0001_0000;
    localparam logic signed [C_W-1:0] C_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [C_W-1:0] C_MIN  = 32'sh8000_0000;

    typedef struct packed {
        logic signed [C_W-1:0] sum;
        logic                  ovf;
        logic                  err;
    } sum_rec_t;

    typedef struct packed {
        logic signed [X_W-1:0] x;
        logic signed [C_W-1:0] c;
        logic                  last;
        logic                  typed;
        logic signed [C_W-1:0] sum;
        logic                  ovf;
        logic                  err;
    } coef_row_t;

    // x, coef, last, typed, sum, overflow, order_error
    localparam coef_row_t DIRECTED [0:22] = '{
        '{16'sh0000, 32'sh0,  1'b1, 1'b1, 32'sh0000_0000, 1'b0, 1'b0},
        '{16'sh0000, 32'sh1,  1'b1, 1'b1, 32'sh0000_0001, 1'b0, 1'b0},
        '{16'shFFFF, C_MAX,   1'b1, 1'b1, 32'sh4000_0000, 1'b0, 1'b0},
        '{X_MAX,     C_MIN,   1'b1, 1'b1, 32'shC000_0000, 1'b0, 1'b0},
        '{X_MAX,     C_MAX,   1'b0, 1'b0, 32'sh0,         1'b0, 1'b0},
        '{X_MAX,     C_MAX,   1'b1, 1'b1, 32'sh7FFF_FFFF, 1'b1, 1'b0},
        '{X_MAX,     C_MIN,   1'b0, 1'b0, 32'sh0,         1'b0, 1'b0},
        '{X_MAX,     C_MIN,   1'b1, 1'b1, 32'sh8000_0000, 1'b1, 1'b0},
        // x = -1, eleven unit coefficients, one extra ignored item
        '{X_NEG1,    C_ONE,   1'b0, 1'b0, 32'sh0,         1'b0, 1'b0},
        '{16'sh1234, C_ONE,   1'b0, 1'b0, 32'sh0,         1'b0, 1'b0},
        '{16'sh1234, C_ONE,   1'b0, 1'b0, 32'sh0,         1'b0, 1'b0},
        '{16'sh1234, C_ONE,   1'b0, 1'b0, 32'sh0,         1'b0, 1'b0},
        '{16'sh1234, C_ONE,   1'b0, 1'b0, 32'sh0,         1'b0, 1'b0},
        '{16'sh1234, C_ONE,   1'b0, 1'b0, 32'sh0,         1'b0, 1'b0},
        '{16'sh1234, C_ONE,   1'b0, 1'b0, 32'sh0,         1'b0, 1'b0},
        '{16'sh1234, C_ONE,   1'b0, 1'b0, 32'sh0,         1'b0, 1'b0},
        '{16'sh1234, C_ONE,   1'b0, 1'b0, 32'sh0,         1'b0, 1'b0},
        '{16'sh1234, C_ONE,   1'b0, 1'b0, 32'sh0,         1'b0, 1'b0},
        '{16'sh1234, C_ONE,   1'b0, 1'b0, 32'sh0,         1'b0, 1'b0},
        '{X_MAX,     C_MAX,   1'b1, 1'b1, 32'sh0005_8000, 1'b0, 1'b1},
        '{16'sh4000, C_ONE,   1'b0, 1'b0, 32'sh0,         1'b0, 1'b0},
        '{X_NEG1,    C_ONE,   1'b0, 1'b0, 32'sh0,         1'b0, 1'b0},
        '{X_MAX,     -C_ONE,  1'b1, 1'b0, 32'sh0,         1'b0, 1'b0}
    };

    logic                  aclk       = 1'b0;
    logic                  aresetn    = 1'b0;
    logic                  s_valid    = 1'b0;
    logic                  s_ready;
    logic signed [X_W-1:0] s_abscissa = '0;
    logic signed [C_W-1:0] s_coef     = '0;
    logic                  s_last     = 1'b0;
    logic                  m_valid;
    logic                  m_ready    = 1'b0;
    logic signed [C_W-1:0] m_sum;
    logic                  m_overflow;
    logic                  m_order_error;

    // series model state
    logic [ORD_W-1:0]      ord_cnt  = '0;
    bit                    ser_full = 1'b0;
    logic signed [X_W-1:0] x_lat    = '0;
    longint                p_l1     = 0;
    longint                p_l2     = 0;
    longint                acc_q    = 0;
    bit                    psat     = 1'b0;
    bit                    perr     = 1'b0;

    sum_rec_t    pending_sums [$];
    int          items_sent = 0;
    int          mism_cnt   = 0;
    int unsigned cyc        = 0;
    int unsigned idle_cyc   = 0;

    legendre_series_eval_core #(.MAX_ORDER(MAX_ORD)) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_abscissa    (s_abscissa),
        .s_coef        (s_coef),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sum         (m_sum),
        .m_overflow    (m_overflow),
        .m_order_error (m_order_error)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Folds one coefficient into the running series; returns 1 with the
    // saturated sum when the item closes the series.
    function automatic bit fold_coef(input logic signed [X_W-1:0] xin,
                                     input logic signed [C_W-1:0] cin,
                                     input logic lst, output sum_rec_t res);
        longint l, num, mag, d, q, p, a, s;
        bit     ov;
        res = '0;
        if (ser_full) begin
            perr = 1'b1;
        end else begin
            l = longint'(ord_cnt);
            if (l == 0) begin
                x_lat = xin;
                p_l2  = 0;
                p     = 64'sd1 <<< 30;
            end else begin
                num = (2 * l - 1) * longint'(x_lat) * p_l1 - (l - 1) * p_l2 * 32768;
                d   = l <<< 15;
                mag = (num < 0) ? -num : num;
                q   = (mag + d / 2) / d;
                if (q > Q_CLAMP)
                    q = Q_CLAMP;
                p = (num < 0) ? -q : q;
                if (p > P_MAX) begin
                    p    = P_MAX;
                    psat = 1'b1;
                end else if (p < P_MIN) begin
                    p    = P_MIN;
                    psat = 1'b1;
                end
                p_l2 = p_l1;
            end
            p_l1  = p;
            a     = (longint'(cin) * p) >>> 14;
            acc_q = acc_q + ((a * (2 * l + 1) + (64'sd1 <<< 16)) >>> 17);
            if (l >= MAX_ORD)
                ser_full = 1'b1;
            else
                ord_cnt = ord_cnt + 1'b1;
        end
        if (!lst)
            return 1'b0;
        s  = acc_q;
        ov = psat;
        if (s > P_MAX) begin
            s  = P_MAX;
            ov = 1'b1;
        end else if (s < P_MIN) begin
            s  = P_MIN;
            ov = 1'b1;
        end
        res.sum  = s[C_W-1:0];
        res.ovf  = ov;
        res.err  = perr;
        ord_cnt  = '0;
        ser_full = 1'b0;
        x_lat    = '0;
        p_l1     = 0;
        p_l2     = 0;
        acc_q    = 0;
        psat     = 1'b0;
        perr     = 1'b0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mism_cnt++;
    endtask

    // Leaves s_valid high after the transfer; the next call decides on a gap.
    task automatic send_coef(input coef_row_t row);
        int       gap;
        sum_rec_t res;
        sum_rec_t typed_res;
        gap = 0;
        if (!(items_sent >= 250 && items_sent < 350))
            while ($urandom_range(0, 99) < 35) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_abscissa <= row.x;
        s_coef     <= row.c;
        s_last     <= row.last;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (fold_coef(row.x, row.c, row.last, res)) begin
            if (row.typed) begin
                typed_res.sum = row.sum;
                typed_res.ovf = row.ovf;
                typed_res.err = row.err;
                pending_sums.push_back(typed_res);
            end else begin
                pending_sums.push_back(res);
            end
        end
    endtask

    task automatic send_series();
        int                    n;
        logic signed [X_W-1:0] x;
        coef_row_t             row;
        case ($urandom_range(0, 9))
            0:       n = 1;
            1:       n = MAX_ORD + 1;
            2:       n = $urandom_range(MAX_ORD + 2, 15);
            default: n = $urandom_range(2, MAX_ORD);
        endcase
        case ($urandom_range(0, 7))
            0:       x = X_NEG1;
            1:       x = X_MAX;
            2:       x = '0;
            default: x = $urandom;
        endcase
        for (int i = 0; i < n; i++) begin
            row      = '0;
            row.x    = (i == 0) ? x : X_W'($urandom);
            row.last = (i == n - 1);
            case ($urandom_range(0, 5))
                0:       row.c = $urandom;
                1:       row.c = $urandom_range(0, 1) ? C_MAX : C_MIN;
                2:       row.c = '0;
                default: row.c = $signed($urandom) >>> 13;
            endcase
            send_coef(row);
        end
    endtask

    // result side: random backpressure with a steady window
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= (cyc >= 9000 && cyc < 15000) || ($urandom_range(0, 99) >= 35);
    end

    always @(posedge aclk) begin : result_check
        sum_rec_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_sums.size() == 0) begin
                report_mismatch($sformatf("unexpected result transfer sum=%h", m_sum));
            end else begin
                want = pending_sums.pop_front();
                if (m_sum !== want.sum)
                    report_mismatch($sformatf("sum %h, want %h", m_sum, want.sum));
                if (m_overflow !== want.ovf)
                    report_mismatch($sformatf("overflow %b, want %b",
                                              m_overflow, want.ovf));
                if (m_order_error !== want.err)
                    report_mismatch($sformatf("order_error %b, want %b",
                                              m_order_error, want.err));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cyc <= 0;
        else
            idle_cyc <= idle_cyc + 1;
        if (idle_cyc >= IDLE_LIM) begin
            $display("timeout: no transfer in %0d cycles", IDLE_LIM);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : stimulus
        bit drained;
        drained = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int i = 0; i < $size(DIRECTED); i++)
            send_coef(DIRECTED[i]);
        while (items_sent < N_ITEMS) begin
            if (!drained && items_sent >= 420) begin
                drained = 1'b1;
                s_valid <= 1'b0;
                do @(posedge aclk); while (pending_sums.size() != 0);
            end
            send_series();
        end
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_sums.size() != 0);
        repeat (60) @(posedge aclk);
        if (mism_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### sim.f
rtl/core/lse_pkg.sv
rtl/core/lse_div.sv
rtl/core/lse_dp.sv
rtl/core/lse_seq.sv
rtl/core/legendre_series_eval_core.sv
tb/legendre_series_eval_core_tb.sv
